// ===== rtl/clr_pkg.sv =====
// shared types, widths and reset values for the clipped line rasterizer
package clr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_W          = 12;
  localparam int PITCH_W        = 13;
  localparam int ADDR_W         = 24;
  localparam int COLOR_W        = 16;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 12'd480;
  localparam logic [PITCH_W-1:0] PITCH_RESET  = 13'd640;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_ROW_PITCH     = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/clipped_line_rasterizer.sv =====
// clipped line rasterizer: bresenham stepping, screen clip and framebuffer address
//
// item channel (item_valid / item_stall): op 0 loads a line from x_start, y_start,
// x_end, y_end and pen_color and yields the start pixel; op 1 advances one pixel of an active line.
// pixel channel (pixel_valid / pixel_stall): one pixel per item with coordinates,
// address y * row_pitch + x (0 when clipped), color, write_enable (on screen) and line_done.
// the line state updates in the item transfer cycle and the pixel goes to the stage 1
// register; the clip and address multiply follow one stage later, into the output
// register. throughput is one item per cycle while the pixel side does not stall.
// a stall on the pixel side holds the output register; the two internal stages
// keep accepting until both are full, then item_stall rises in the same cycle.
// reset (rst, synchronous) drops all pipeline contents, clears the line state and
// loads the screen registers with 640 x 480, pitch 640.
// cfg_write writes register cfg_index (0 width, 1 height, 2 pitch) from cfg_data;
// write only while no items are in flight.
module clipped_line_rasterizer
  import clr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         op,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  input  logic [COLOR_W-1:0]           pen_color,
  output logic                         pixel_valid,
  input  logic                         pixel_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [ADDR_W-1:0]            pixel_address,
  output logic [COLOR_W-1:0]           pixel_color,
  output logic                         write_enable,
  output logic                         line_done
);

  localparam int C      = COORD_BITS;
  localparam int D_W    = C + 1;
  localparam int E_W    = C + 3;
  localparam int CMP_W  = ((C > DIM_W) ? C : DIM_W) + 1;
  localparam int PROD_RAW = C + PITCH_W + 1;
  localparam int PROD_W = (PROD_RAW > ADDR_W) ? PROD_RAW : ADDR_W;

  // screen registers
  logic [DIM_W-1:0]   screen_width;
  logic [DIM_W-1:0]   screen_height;
  logic [PITCH_W-1:0] row_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      row_pitch     <= PITCH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[DIM_W-1:0];
        REG_ROW_PITCH:     row_pitch     <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // line state
  logic signed [C-1:0]   cur_x, cur_y, end_x, end_y;
  logic signed [E_W-1:0] err_term;
  logic [D_W-1:0]        twice_dx, twice_dy;
  logic                  x_negative, y_negative, x_major, active;
  logic [COLOR_W-1:0]    line_color;

  logic signed [C-1:0]   cur_x_next, cur_y_next, end_x_next, end_y_next;
  logic signed [E_W-1:0] err_term_next;
  logic [D_W-1:0]        twice_dx_next, twice_dy_next;
  logic                  x_negative_next, y_negative_next, x_major_next, active_next;
  logic [COLOR_W-1:0]    line_color_next;
  logic                  live_next, done_next;

  // pipeline control
  logic s1_valid;
  logic adv1, adv2, item_xfer;

  assign adv2       = !pixel_valid || !pixel_stall;
  assign adv1       = !s1_valid || adv2;
  assign item_stall = !adv1;
  assign item_xfer  = item_valid && adv1;

  // load path
  logic signed [C:0]     diff_x, diff_y;
  logic [C-1:0]          dx, dy;
  logic [D_W-1:0]        ld_tdx, ld_tdy;
  logic                  ld_xneg, ld_yneg, ld_xmaj;
  logic signed [E_W-1:0] ld_err;

  // step path
  logic                  take_minor;
  logic signed [E_W:0]   err_sum;
  logic signed [C-1:0]   step_x, step_y;

  always_comb begin
    ld_xneg = !(x_end > x_start);
    ld_yneg = !(y_end > y_start);
    diff_x  = ld_xneg ? (D_W'(x_start) - D_W'(x_end)) : (D_W'(x_end) - D_W'(x_start));
    diff_y  = ld_yneg ? (D_W'(y_start) - D_W'(y_end)) : (D_W'(y_end) - D_W'(y_start));
    dx      = diff_x[C-1:0];
    dy      = diff_y[C-1:0];
    ld_tdx  = {dx, 1'b0};
    ld_tdy  = {dy, 1'b0};
    ld_xmaj = ld_tdx >= ld_tdy;
    ld_err  = ld_xmaj ? ($signed(E_W'(ld_tdy)) - $signed(E_W'(dx)))
                      : ($signed(E_W'(ld_tdx)) - $signed(E_W'(dy)));

    take_minor = (err_term > 0) ||
                 ((err_term == 0) && !(x_major ? x_negative : y_negative));
    if (x_major) begin
      err_sum = $signed((E_W+1)'(err_term))
              - (take_minor ? $signed((E_W+1)'(twice_dx)) : '0)
              + $signed((E_W+1)'(twice_dy));
      step_x  = x_negative ? cur_x - C'(1) : cur_x + C'(1);
      step_y  = !take_minor ? cur_y : (y_negative ? cur_y - C'(1) : cur_y + C'(1));
    end else begin
      err_sum = $signed((E_W+1)'(err_term))
              - (take_minor ? $signed((E_W+1)'(twice_dy)) : '0)
              + $signed((E_W+1)'(twice_dx));
      step_y  = y_negative ? cur_y - C'(1) : cur_y + C'(1);
      step_x  = !take_minor ? cur_x : (x_negative ? cur_x - C'(1) : cur_x + C'(1));
    end

    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    end_x_next      = end_x;
    end_y_next      = end_y;
    err_term_next   = err_term;
    twice_dx_next   = twice_dx;
    twice_dy_next   = twice_dy;
    x_negative_next = x_negative;
    y_negative_next = y_negative;
    x_major_next    = x_major;
    line_color_next = line_color;
    active_next     = active;
    live_next       = 1'b0;
    done_next       = 1'b1;

    if (op == OP_LOAD) begin
      cur_x_next      = x_start;
      cur_y_next      = y_start;
      end_x_next      = x_end;
      end_y_next      = y_end;
      err_term_next   = ld_err;
      twice_dx_next   = ld_tdx;
      twice_dy_next   = ld_tdy;
      x_negative_next = ld_xneg;
      y_negative_next = ld_yneg;
      x_major_next    = ld_xmaj;
      line_color_next = pen_color;
      done_next       = ld_xmaj ? (x_start == x_end) : (y_start == y_end);
      active_next     = !done_next;
      live_next       = 1'b1;
    end else if (active) begin
      cur_x_next    = step_x;
      cur_y_next    = step_y;
      err_term_next = err_sum[E_W-1:0];
      done_next     = x_major ? (step_x == end_x) : (step_y == end_y);
      active_next   = !done_next;
      live_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      end_x      <= '0;
      end_y      <= '0;
      err_term   <= '0;
      twice_dx   <= '0;
      twice_dy   <= '0;
      x_negative <= 1'b0;
      y_negative <= 1'b0;
      x_major    <= 1'b0;
      line_color <= '0;
      active     <= 1'b0;
    end else if (item_xfer) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      end_x      <= end_x_next;
      end_y      <= end_y_next;
      err_term   <= err_term_next;
      twice_dx   <= twice_dx_next;
      twice_dy   <= twice_dy_next;
      x_negative <= x_negative_next;
      y_negative <= y_negative_next;
      x_major    <= x_major_next;
      line_color <= line_color_next;
      active     <= active_next;
    end
  end

  // stage 1: pixel before clip
  logic signed [C-1:0] s1_x, s1_y;
  logic [COLOR_W-1:0]  s1_color;
  logic                s1_live, s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      s1_x     <= cur_x_next;
      s1_y     <= cur_y_next;
      s1_color <= line_color_next;
      s1_live  <= live_next;
      s1_done  <= done_next;
    end
  end

  // stage 2: clip and address
  logic              on_screen;
  logic [PROD_W-1:0] addr_full;

  always_comb begin
    on_screen = s1_live && !s1_x[C-1] && !s1_y[C-1] &&
                (CMP_W'($unsigned(s1_x)) < CMP_W'(screen_width)) &&
                (CMP_W'($unsigned(s1_y)) < CMP_W'(screen_height));
    addr_full = PROD_W'($unsigned(s1_y)) * PROD_W'(row_pitch) + PROD_W'($unsigned(s1_x));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (adv2) begin
      pixel_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      pixel_x       <= s1_x;
      pixel_y       <= s1_y;
      pixel_address <= on_screen ? addr_full[ADDR_W-1:0] : '0;
      pixel_color   <= s1_color;
      write_enable  <= on_screen;
      line_done     <= s1_done;
    end
  end

`ifndef SYNTHESIS
  a_we_nonneg: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && write_enable |-> !pixel_x[C-1] && !pixel_y[C-1])
    else $error("write enabled on a negative coordinate");

  a_clip_addr: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !write_enable |-> pixel_address == '0)
    else $error("clipped pixel carries a nonzero address");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    item_xfer && op == OP_STEP && !active |=> $stable(cur_x) && $stable(cur_y) && !active)
    else $error("step without a line changed the line state");

  a_dead_done: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_live |-> s1_done)
    else $error("pixel without a line not marked done");

  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    item_xfer && done_next |=> !active)
    else $error("line still active after its end point");
`endif

endmodule

// ===== tb/sv/line_raster_pkg.sv =====
// pixel predictor and result check for the clipped line rasterizer testbench
package line_raster_pkg;
  import clr_pkg::*;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  typedef struct packed {
    coord_t              x;
    coord_t              y;
    logic [ADDR_W-1:0]   address;
    logic [COLOR_W-1:0]  color;
    logic                write_enable;
    logic                line_done;
  } pixel_t;

  class line_raster;
    logic [DIM_W-1:0]   screen_width;
    logic [DIM_W-1:0]   screen_height;
    logic [PITCH_W-1:0] row_pitch;
    coord_t             cur_x, cur_y, end_x, end_y;
    int                 err_term, twice_dx, twice_dy;
    bit                 x_negative, y_negative, x_major, active;
    logic [COLOR_W-1:0] line_color;
    pixel_t             pending_pixels[$];
    int                 errors, loads, steps, on_screen, clipped;

    function new();
      screen_width  = WIDTH_RESET;
      screen_height = HEIGHT_RESET;
      row_pitch     = PITCH_RESET;
      cur_x = '0; cur_y = '0; end_x = '0; end_y = '0;
      err_term = 0; twice_dx = 0; twice_dy = 0;
      x_negative = 0; y_negative = 0; x_major = 0; active = 0;
      line_color = '0;
    endfunction

    function void write_reg(cfg_reg_t index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_SCREEN_WIDTH:  screen_width  = value[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height = value[DIM_W-1:0];
        REG_ROW_PITCH:     row_pitch     = value[PITCH_W-1:0];
        default: ;
      endcase
    endfunction

    function pixel_t make_pixel(bit live, bit done);
      pixel_t p;
      int     cx, cy;
      bit     seen;
      cx = cur_x;
      cy = cur_y;
      seen = live && cx >= 0 && cx < int'(screen_width) &&
             cy >= 0 && cy < int'(screen_height);
      p.x = cur_x;
      p.y = cur_y;
      p.address = seen ? ADDR_W'(cy * int'(row_pitch) + cx) : '0;
      p.color = line_color;
      p.write_enable = seen;
      p.line_done = done;
      if (seen) on_screen++;
      else clipped++;
      return p;
    endfunction

    function void note_item(op_t op, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                            logic [COLOR_W-1:0] color);
      bit done;
      if (op == OP_LOAD) begin
        loads++;
        x_negative = !(xe > xs);
        y_negative = !(ye > ys);
        twice_dx = 2 * (x_negative ? int'(xs) - int'(xe) : int'(xe) - int'(xs));
        twice_dy = 2 * (y_negative ? int'(ys) - int'(ye) : int'(ye) - int'(ys));
        x_major = twice_dx >= twice_dy;
        err_term = x_major ? twice_dy - twice_dx / 2 : twice_dx - twice_dy / 2;
        cur_x = xs; cur_y = ys; end_x = xe; end_y = ye;
        line_color = color;
        done = x_major ? (cur_x == end_x) : (cur_y == end_y);
        active = !done;
        pending_pixels.push_back(make_pixel(1'b1, done));
      end else if (!active) begin
        steps++;
        pending_pixels.push_back(make_pixel(1'b0, 1'b1));
      end else begin
        steps++;
        if (x_major) begin
          if (err_term > 0 || (err_term == 0 && !x_negative)) begin
            cur_y = y_negative ? cur_y - 1 : cur_y + 1;
            err_term -= twice_dx;
          end
          cur_x = x_negative ? cur_x - 1 : cur_x + 1;
          err_term += twice_dy;
          done = cur_x == end_x;
        end else begin
          if (err_term > 0 || (err_term == 0 && !y_negative)) begin
            cur_x = x_negative ? cur_x - 1 : cur_x + 1;
            err_term -= twice_dy;
          end
          cur_y = y_negative ? cur_y - 1 : cur_y + 1;
          err_term += twice_dx;
          done = cur_y == end_y;
        end
        if (done) active = 0;
        pending_pixels.push_back(make_pixel(1'b1, done));
      end
    endfunction

    function void report_field(string field, logic signed [ADDR_W:0] want,
                               logic signed [ADDR_W:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel transfer, expected none, got x %0d y %0d",
                 $time, got.x, got.y);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x !== want.x) report_field("pixel_x", want.x, got.x);
      if (got.y !== want.y) report_field("pixel_y", want.y, got.y);
      if (got.address !== want.address) report_field("pixel_address", want.address, got.address);
      if (got.color !== want.color) report_field("pixel_color", want.color, got.color);
      if (got.write_enable !== want.write_enable)
        report_field("write_enable", want.write_enable, got.write_enable);
      if (got.line_done !== want.line_done)
        report_field("line_done", want.line_done, got.line_done);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/clipped_line_rasterizer_tb.sv =====
// top-level testbench: drives lines through the rasterizer and checks every pixel
module clipped_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clr_pkg::*;
  import line_raster_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  cfg_reg_t           cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  op_t                op = OP_LOAD;
  coord_t             x_start = '0;
  coord_t             y_start = '0;
  coord_t             x_end = '0;
  coord_t             y_end = '0;
  logic [COLOR_W-1:0] pen_color = '0;
  logic               pixel_valid;
  logic               pixel_stall = 1'b0;
  coord_t             pixel_x;
  coord_t             pixel_y;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               write_enable;
  logic               line_done;

  line_raster raster = new();
  bit         tx_gappy = 1'b1;
  bit         no_gaps = 1'b0;
  bit         hold_request = 1'b0;
  int         settings_used = 1;

  clipped_line_rasterizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .op            (op),
    .x_start       (x_start),
    .y_start       (y_start),
    .x_end         (x_end),
    .y_end         (y_end),
    .pen_color     (pen_color),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .write_enable  (write_enable),
    .line_done     (line_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      raster.note_item(op, x_start, y_start, x_end, y_end, pen_color);
    if (!rst && pixel_valid && !pixel_stall)
      raster.check_pixel(pixel_t'{pixel_x, pixel_y, pixel_address, pixel_color,
                                  write_enable, line_done});
  end

  // receiver: random stall before each pixel transfer, one long hold on request
  initial begin
    int stall_len;
    bit rx_gappy;
    rx_gappy = 1'b1;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_gappy = !rx_gappy;
      if (hold_request) begin
        stall_len = 300;
        hold_request = 1'b0;
      end else begin
        stall_len = rx_gappy ? $urandom_range(0, 11) : 0;
      end
      if (stall_len > 0) begin
        pixel_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        pixel_stall <= 1'b0;
      end
      do @(posedge clk); while (!pixel_valid);
    end
  end

  function automatic coord_t clamp_coord(int v);
    if (v > 2047) return coord_t'(2047);
    if (v < -2048) return coord_t'(-2048);
    return coord_t'(v);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, 4095));
  endfunction

  task automatic send_item(op_t kind, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                           logic [COLOR_W-1:0] color);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_gappy = !tx_gappy;
    gap = (tx_gappy && !no_gaps) ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= kind;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    pen_color <= color;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (raster.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_screen(int w, int h, int p);
    cfg_write <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    raster.write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(w));
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    raster.write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(h));
    @(posedge clk);
    cfg_index <= REG_ROW_PITCH;
    cfg_data <= CFG_DATA_W'(p);
    raster.write_reg(REG_ROW_PITCH, CFG_DATA_W'(p));
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic step_pixels(int n);
    repeat (n) send_item(OP_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                         COLOR_W'($urandom()));
  endtask

  // mostly whole lines near the screen window, some long or cut short, some noise
  task automatic random_lines(int n_items, int win_x, int win_y);
    int     sent, kind, x0, y0, len, n_steps;
    coord_t xs, ys, xe, ye;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send_item($urandom_range(0, 1) ? OP_STEP : OP_LOAD, any_coord(), any_coord(),
                  any_coord(), any_coord(), COLOR_W'($urandom()));
        sent++;
      end else begin
        if (kind < 3) begin
          xs = any_coord(); ys = any_coord(); xe = any_coord(); ye = any_coord();
        end else begin
          x0 = $urandom_range(0, win_x + 16) - 8;
          y0 = $urandom_range(0, win_y + 16) - 8;
          xs = clamp_coord(x0);
          ys = clamp_coord(y0);
          xe = clamp_coord(x0 + $urandom_range(0, 48) - 24);
          ye = clamp_coord(y0 + $urandom_range(0, 48) - 24);
        end
        len = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
        x0 = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
        if (x0 > len) len = x0;
        n_steps = len + $urandom_range(0, 2);
        if (kind < 3 || $urandom_range(0, 9) == 0)
          n_steps = $urandom_range(0, (len < 30) ? len : 30);
        send_item(OP_LOAD, xs, ys, xe, ye, COLOR_W'($urandom()));
        step_pixels(n_steps);
        sent += 1 + n_steps;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step with no line loaded, then a degenerate line
    step_pixels(1);
    send_item(OP_LOAD, 5, 5, 5, 5, 16'hFFFF);
    step_pixels(1);
    // zero error ties in both directions
    send_item(OP_LOAD, 0, 0, 4, 2, 16'h1234);
    step_pixels(4);
    send_item(OP_LOAD, 4, 2, 0, 0, 16'hABCD);
    step_pixels(4);
    // y-major line crossing the right screen edge
    send_item(OP_LOAD, 639, 479, 641, 476, 16'h5A5A);
    step_pixels(3);
    // full-range diagonals
    send_item(OP_LOAD, -2048, -2048, 2047, 2047, 16'h0000);
    step_pixels(2);
    send_item(OP_LOAD, 2047, 2047, -2048, -2048, 16'hFFFF);
    step_pixels(1);
    // vertical through row zero, equal x steps negative
    send_item(OP_LOAD, 0, 1, 0, -1, 16'h8001);
    step_pixels(2);

    random_lines(300, 660, 500);
    drain();

    set_screen(1, 1, 1);
    random_lines(250, 4, 4);
    drain();

    set_screen(2048, 2048, 4096);
    random_lines(250, 2048, 2048);
    drain();

    set_screen($urandom_range(8, 64), $urandom_range(8, 64), $urandom_range(64, 96));
    hold_request = 1'b1;
    no_gaps = 1'b1;
    random_lines(150, 64, 64);
    no_gaps = 1'b0;
    drain();
    random_lines(150, 64, 64);
    drain();

    set_screen(2048, 1, 1);
    random_lines(250, 100, 4);
    drain();

    set_screen($urandom_range(1, 2048), $urandom_range(1, 2048), $urandom_range(1, 4096));
    random_lines(200, 200, 200);
    drain();

    set_screen(640, 480, 640);
    random_lines(200, 660, 500);
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d line loads and %0d steps over %0d screen settings",
             raster.loads, raster.steps, settings_used);
    $display("%0d pixels written on screen, %0d clipped, %0d mismatches",
             raster.on_screen, raster.clipped, raster.errors);
    if (raster.errors == 0 && raster.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
